// ----- src/drau_pkg.sv -----
// Shared types and constants for the debug register allocator.
package drau_pkg;

    localparam int MAX_SLOTS = 4;
    localparam int SLOT_W    = 2;
    localparam int WORD_W    = 32;
    localparam int CFG_REGS  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] CFG_RESET [CFG_REGS] = '{
        32'd983043, 32'd15728652, 32'd251658288, 32'd4026531968
    };

    localparam logic [2:0] ACT_ALLOC  = 3'd0;
    localparam logic [2:0] ACT_FREE   = 3'd1;
    localparam logic [2:0] ACT_RAISE  = 3'd2;
    localparam logic [2:0] ACT_LOWER  = 3'd3;
    localparam logic [2:0] ACT_CHANGE = 3'd4;

    typedef enum logic [1:0] {
        KIND_UNUSED = 2'd0,
        KIND_LOCAL  = 2'd1,
        KIND_GLOBAL = 2'd2
    } slot_kind_t;

    typedef enum logic [2:0] {
        OP_FAIL      = 3'd0,
        OP_NAMED     = 3'd1,
        OP_ANY       = 3'd2,
        OP_FREE      = 3'd3,
        OP_RAISE     = 3'd4,
        OP_LOWER     = 3'd5,
        OP_CHG_ALLOC = 3'd6,
        OP_CHG_FREE  = 3'd7
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                op;
        logic [SLOT_W-1:0]      slot;
        logic                   global_req;
        logic [MAX_SLOTS-1:0]   lanes;
    } cmd_t;

endpackage

// ----- src/drau_front.sv -----
// Front end: accepts request items and classifies them into slot commands.
module drau_front
    import drau_pkg::*;
#(
    parameter int SLOT_COUNT = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          action,
    input  logic [2:0]          slot_select,
    input  logic                any_slot,
    input  logic                global_request,
    input  logic [WORD_W-1:0]   use_mask,
    input  logic [WORD_W-1:0]   old_control,
    input  logic [WORD_W-1:0]   new_control,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output cmd_t                cmd
);

    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] diff;
    logic              in_range;
    logic              found;

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;
    assign diff      = old_control ^ new_control;
    assign in_range  = int'(slot_select) < SLOT_COUNT;

    always_comb
    begin
        cmd_next = '0;
        cmd_next.op = OP_FAIL;
        found = 1'b0;
        case (action)
            ACT_ALLOC:
            begin
                if (any_slot)
                begin
                    cmd_next.op = OP_ANY;
                    cmd_next.global_req = global_request;
                end
                else if (in_range)
                begin
                    cmd_next.op = OP_NAMED;
                    cmd_next.slot = slot_select[SLOT_W-1:0];
                    cmd_next.global_req = global_request;
                end
            end
            ACT_FREE:
            begin
                if (in_range)
                begin
                    cmd_next.op = OP_FREE;
                    cmd_next.slot = slot_select[SLOT_W-1:0];
                end
            end
            ACT_RAISE, ACT_LOWER:
            begin
                cmd_next.op = (action == ACT_RAISE) ? OP_RAISE : OP_LOWER;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    cmd_next.lanes[i] = use_mask[2*i];
                end
            end
            ACT_CHANGE:
            begin
                // pick the lowest slot whose local-enable bit flipped
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!found && diff[2*i])
                    begin
                        found = 1'b1;
                        cmd_next.slot = SLOT_W'(i);
                        cmd_next.op = new_control[2*i] ? OP_CHG_ALLOC : OP_CHG_FREE;
                    end
                end
            end
            default:
            begin
                cmd_next.op = OP_FAIL;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ----- src/drau_queue.sv -----
// Two-entry command queue between the front end and the slot sequencer.
module drau_queue
    import drau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- src/drau_back.sv -----
// Back end: slot state, control-bit registers and the command sequencer.
module drau_back
    import drau_pkg::*;
#(
    parameter int SLOT_COUNT = 4,
    parameter int COUNT_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  cmd_t                 q_cmd,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 res_success,
    output logic [SLOT_W-1:0]    res_slot,
    output logic [WORD_W-1:0]    res_gmask
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    cmd_t                   cmd_reg;
    cmd_t                   cmd_next;
    logic [SLOT_W-1:0]      scan_reg;
    logic [SLOT_W-1:0]      scan_next;
    slot_kind_t             kind_reg  [SLOT_COUNT];
    slot_kind_t             kind_next [SLOT_COUNT];
    logic [COUNT_BITS-1:0]  count_reg  [SLOT_COUNT];
    logic [COUNT_BITS-1:0]  count_next [SLOT_COUNT];
    logic [WORD_W-1:0]      gmask_reg;
    logic [WORD_W-1:0]      gmask_next;
    logic [WORD_W-1:0]      bits_reg [CFG_REGS];
    logic                   out_valid_reg;
    logic                   out_success_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [WORD_W-1:0]      out_gmask_reg;
    logic                   finish;
    logic                   fin_ok;
    logic [SLOT_W-1:0]      fin_slot;
    logic                   slot_ok;
    logic                   hit;
    logic                   scan_last;

    function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : COUNT_BITS'(c + 1'b1);
    endfunction

    assign q_ready     = (state_reg == ST_IDLE) && !out_valid_reg;
    assign res_valid   = out_valid_reg;
    assign res_success = out_success_reg;
    assign res_slot    = out_slot_reg;
    assign res_gmask   = out_gmask_reg;
    assign scan_last   = cmd_reg.global_req ? (scan_reg == '0)
                                            : (scan_reg == SLOT_W'(SLOT_COUNT - 1));

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        scan_next  = scan_reg;
        kind_next  = kind_reg;
        count_next = count_reg;
        gmask_next = gmask_reg;
        finish     = 1'b0;
        fin_ok     = 1'b0;
        fin_slot   = '0;
        slot_ok    = 1'b0;
        hit        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    cmd_next   = q_cmd;
                    state_next = (q_cmd.op == OP_ANY) ? ST_SCAN : ST_EXEC;
                    // local scans upward, global scans downward
                    scan_next  = q_cmd.global_req ? SLOT_W'(SLOT_COUNT - 1) : '0;
                end
            end
            ST_EXEC:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    hit = cmd_reg.slot == SLOT_W'(i);
                    case (cmd_reg.op)
                        OP_NAMED, OP_CHG_ALLOC:
                        begin
                            if (hit)
                            begin
                                if (cmd_reg.global_req && kind_reg[i] == KIND_UNUSED)
                                begin
                                    kind_next[i] = KIND_GLOBAL;
                                    gmask_next   = gmask_next | bits_reg[i];
                                    slot_ok      = 1'b1;
                                end
                                else if (kind_reg[i] != KIND_GLOBAL)
                                begin
                                    count_next[i] = count_inc(count_reg[i]);
                                    kind_next[i]  = KIND_LOCAL;
                                    slot_ok       = 1'b1;
                                end
                            end
                        end
                        OP_FREE, OP_CHG_FREE:
                        begin
                            if (hit && kind_reg[i] != KIND_UNUSED)
                            begin
                                slot_ok = 1'b1;
                                if (kind_reg[i] == KIND_LOCAL)
                                begin
                                    if (count_reg[i] != '0)
                                    begin
                                        count_next[i] = COUNT_BITS'(count_reg[i] - 1'b1);
                                        if (count_reg[i] == COUNT_BITS'(1))
                                        begin
                                            kind_next[i] = KIND_UNUSED;
                                        end
                                    end
                                end
                                else
                                begin
                                    kind_next[i]  = KIND_UNUSED;
                                    count_next[i] = '0;
                                    gmask_next    = gmask_next & ~bits_reg[i];
                                end
                            end
                        end
                        OP_RAISE:
                        begin
                            if (cmd_reg.lanes[i])
                            begin
                                count_next[i] = count_inc(count_reg[i]);
                            end
                        end
                        OP_LOWER:
                        begin
                            // saturate at zero; dropping to zero releases the slot
                            if (cmd_reg.lanes[i] && count_reg[i] != '0)
                            begin
                                count_next[i] = COUNT_BITS'(count_reg[i] - 1'b1);
                                if (count_reg[i] == COUNT_BITS'(1))
                                begin
                                    kind_next[i] = KIND_UNUSED;
                                end
                            end
                        end
                        default:
                        begin
                            hit = 1'b0;
                        end
                    endcase
                end
                case (cmd_reg.op)
                    OP_NAMED:
                    begin
                        fin_ok   = slot_ok;
                        fin_slot = slot_ok ? cmd_reg.slot : '0;
                    end
                    OP_CHG_ALLOC:
                    begin
                        fin_ok   = 1'b1;
                        fin_slot = slot_ok ? cmd_reg.slot : '0;
                    end
                    OP_FREE:
                    begin
                        fin_ok = slot_ok;
                    end
                    OP_CHG_FREE, OP_RAISE, OP_LOWER:
                    begin
                        fin_ok = 1'b1;
                    end
                    default:
                    begin
                        fin_ok = 1'b0;
                    end
                endcase
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (scan_reg == SLOT_W'(i))
                    begin
                        if (cmd_reg.global_req)
                        begin
                            if (kind_reg[i] == KIND_UNUSED)
                            begin
                                kind_next[i] = KIND_GLOBAL;
                                gmask_next   = gmask_reg | bits_reg[i];
                                slot_ok      = 1'b1;
                            end
                        end
                        else if (kind_reg[i] == KIND_LOCAL)
                        begin
                            count_next[i] = count_inc(count_reg[i]);
                            slot_ok       = 1'b1;
                        end
                        else if (kind_reg[i] == KIND_UNUSED)
                        begin
                            kind_next[i]  = KIND_LOCAL;
                            count_next[i] = COUNT_BITS'(1);
                            slot_ok       = 1'b1;
                        end
                    end
                end
                if (slot_ok || scan_last)
                begin
                    finish     = 1'b1;
                    fin_ok     = slot_ok;
                    fin_slot   = slot_ok ? scan_reg : '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = cmd_reg.global_req ? SLOT_W'(scan_reg - 1'b1)
                                                   : SLOT_W'(scan_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            gmask_reg     <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                kind_reg[i]  <= KIND_UNUSED;
                count_reg[i] <= '0;
            end
            for (int j = 0; j < CFG_REGS; j++)
            begin
                bits_reg[j] <= CFG_RESET[j];
            end
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            gmask_reg <= gmask_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                bits_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        scan_reg <= scan_next;
        if (finish)
        begin
            out_success_reg <= fin_ok;
            out_slot_reg    <= fin_slot;
            out_gmask_reg   <= gmask_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) finish |-> !out_valid_reg)
        else $error("result written over a waiting item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_success_reg |-> out_slot_reg == '0)
        else $error("failed request reports a granted slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) != ST_IDLE)
        else $error("result raised without a command in progress");

    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_chk
        assert property (@(posedge clk) disable iff (!rst_n)
            kind_reg[g] == KIND_LOCAL |-> count_reg[g] != '0)
            else $error("local slot holds a zero reference count");
    end

endmodule

// ----- src/debug_register_allocator_unit.sv -----
// Top level of the debug register allocator: port packing and unit hookup.
//
// Request items enter on the s_* stream: tuser carries the action code and
// tdata the slot number, flags, count mask and the two control words.
// Each request yields one result item on the m_* stream with the success
// flag, the granted slot and the global control mask after the request.
// The cfg_* channel writes the four per-slot control-bit registers; it is
// always ready, and the user must write it only while no request is in
// flight, which the block itself does not enforce. A front stage classifies
// each item into a slot command and pushes it into a two-entry queue; the
// slot sequencer pops one command at a time. Named, free, count and
// control-change requests run in a single execute state; an any-slot
// allocation instead scans, checking one slot per cycle and up to SLOT_COUNT
// slots until one fits. The sequencer pops a new command only after the last
// one is done and its result has been taken; the front and queue keep
// taking items meanwhile.
// Reset clears all slots to unused, counts and the global mask to zero,
// and loads the control-bit registers with their defaults. A stalled
// result holds in the output register; the front and queue keep taking
// up to three more items before s_tready drops.
module debug_register_allocator_unit
    import drau_pkg::*;
#(
    parameter int SLOT_COUNT = 4,
    parameter int COUNT_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] slot_select, [3] any_slot, [4] global_request, [36:5] use_mask,
    // [68:37] old_control, [100:69] new_control, [103:101] zero
    input  logic [103:0]         s_tdata,
    // [2:0] action
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] success, [2:1] slot_granted, [34:3] global_mask, [39:35] zero
    output logic [39:0]          m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic              f_valid;
    logic              f_ready;
    cmd_t              f_cmd;
    logic              q_valid;
    logic              q_ready;
    cmd_t              q_cmd;
    logic              res_success;
    logic [SLOT_W-1:0] res_slot;
    logic [WORD_W-1:0] res_gmask;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {5'd0, res_gmask, res_slot, res_success};

    drau_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .action         (s_tuser),
        .slot_select    (s_tdata[2:0]),
        .any_slot       (s_tdata[3]),
        .global_request (s_tdata[4]),
        .use_mask       (s_tdata[36:5]),
        .old_control    (s_tdata[68:37]),
        .new_control    (s_tdata[100:69]),
        .cmd_valid      (f_valid),
        .cmd_ready      (f_ready),
        .cmd            (f_cmd)
    );

    drau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    drau_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_cmd       (q_cmd),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_success (res_success),
        .res_slot    (res_slot),
        .res_gmask   (res_gmask)
    );

endmodule
